// ----- rtl/ccomb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccomb_pkg
// Shared types and constants for the control signal combiner.
// ----------------------------------------------------------------------------
package ccomb_pkg;

  localparam int VAL_W          = 24;
  localparam int MODE_W         = 4;
  localparam int PROD_W         = 50;
  localparam int MUL_X_W        = 26;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_STEPS_DEF  = 16;
  localparam int COEF_SHIFT     = 16;

  localparam int VAL_MAX        = 8388607;
  localparam int VAL_MIN        = -8388608;
  localparam int LP_KEEP        = 64881;
  localparam int LP_TAKE        = 655;
  localparam int THIRD_Q16      = 21845;
  localparam int ROUND_Q16      = 32768;
  localparam int QUANT_GAIN     = 15;

  typedef enum logic [MODE_W-1:0] {
    MODE_ZERO     = 4'd0,
    MODE_ADD      = 4'd1,
    MODE_SUB      = 4'd2,
    MODE_MUL      = 4'd3,
    MODE_MEAN     = 4'd4,
    MODE_HALFA_B  = 4'd5,
    MODE_QUANT    = 4'd6,
    MODE_LOWPASS  = 4'd7,
    MODE_SAMPLE   = 4'd8,
    MODE_TRACK    = 4'd9,
    MODE_OR       = 4'd10,
    MODE_MAX      = 4'd11,
    MODE_MIN      = 4'd12,
    MODE_WEIGHTED = 4'd13,
    MODE_ABSDIFF  = 4'd14
  } mode_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic acc1;
    logic mul2;
    logic acc2;
    logic div_step;
    logic fin;
  } ccomb_cmd_t;

  typedef struct packed {
    logic quant;
    logic div_done;
    logic out_free;
  } ccomb_status_t;

endpackage
`default_nettype wire

// ----- rtl/ccomb_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccomb_in_if
// Input channel: one word carries a, b and the note start flag.
// ----------------------------------------------------------------------------
interface ccomb_in_if import ccomb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] a_value;
  logic signed [VAL_W-1:0] b_value;
  logic                    note_start;

  modport source (output valid, output a_value, output b_value, output note_start,
                  input ready);
  modport sink   (input valid, input a_value, input b_value, input note_start,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/ccomb_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccomb_out_if
// Result channel: one word carries the combined value.
// ----------------------------------------------------------------------------
interface ccomb_out_if import ccomb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;

  modport source (output valid, output result_value, input ready);
  modport sink   (input valid, input result_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/ccomb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccomb_ctrl
// Sequencer: drives multiply, accumulate, quantize-only divide, finish steps.
// ----------------------------------------------------------------------------
module ccomb_ctrl import ccomb_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ccomb_status_t status,
  output ccomb_cmd_t         cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_ACC1 = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_ACC2 = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_ACC1;
      end
      ST_ACC1: begin
        cmd.acc1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_ACC2;
      end
      ST_ACC2: begin
        cmd.acc2  = 1'b1;
        state_nxt = status.quant ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ccomb_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccomb_dp
// Datapath: shared multiplier, accumulator, bit-serial divider, held state
// and the output register.
// ----------------------------------------------------------------------------
module ccomb_dp import ccomb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ccomb_cmd_t              cmd,
  output ccomb_status_t                status,
  input  wire logic                    cfg_we,
  input  wire logic [MODE_W-1:0]       cfg_data,
  input  wire logic signed [VAL_W-1:0] in_a,
  input  wire logic signed [VAL_W-1:0] in_b,
  input  wire logic                    in_note,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [VAL_W-1:0]      out_result
);

  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int DW = VAL_W - 1 + SW;
  localparam int CW = $clog2(DW);
  localparam logic signed [PROD_W-1:0] ONE_W  = PROD_W'(1) <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] HALF_W = ONE_W >>> 1;
  localparam logic signed [PROD_W-1:0] VMAX_W = PROD_W'(VAL_MAX);
  localparam logic signed [PROD_W-1:0] VMIN_W = PROD_W'(VAL_MIN);

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [PROD_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > VMAX_W) begin
      r = VAL_W'(VAL_MAX);
    end else if (v < VMIN_W) begin
      r = VAL_W'(VAL_MIN);
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] clip_one(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] r;
    if (v > ONE_W) begin
      r = ONE_W;
    end else if (v < -ONE_W) begin
      r = -ONE_W;
    end else begin
      r = v;
    end
    return r;
  endfunction

  mode_t                     op_mode_r;
  logic signed [VAL_W-1:0]   a_r, b_r;
  logic signed [VAL_W-1:0]   z_r, z_nxt;
  logic signed [VAL_W-1:0]   held_r, held_nxt;
  logic                      gate_r, gate_nxt;
  logic signed [PROD_W-1:0]  prod_r, acc_r;
  logic [SW-1:0]             steps_r;
  logic [DW-1:0]             quo_r;
  logic [SW-1:0]             rem_r;
  logic                      neg_r;
  logic [CW-1:0]             cnt_r;
  logic signed [VAL_W-1:0]   res_r;
  logic                      out_valid_r;

  logic signed [MUL_X_W-1:0] mul_x;
  logic signed [VAL_W-1:0]   mul_y;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [MUL_X_W-1:0] a_x, b_x, a_abs;
  logic signed [PROD_W-1:0]  a_w, b_w, quo_w, quant_v, res_w, steps_raw, p_mag, dvd;
  logic [SW-1:0]             steps_nxt;
  logic [SW:0]               rem_sh;
  logic                      rem_ge;
  logic                      a_gt_half, a_ge_half, b_gt_half;
  logic signed [VAL_W-1:0]   lp_v;

  assign a_x   = MUL_X_W'(a_r);
  assign b_x   = MUL_X_W'(b_r);
  assign a_abs = a_r[VAL_W-1] ? -a_x : a_x;
  assign a_w   = PROD_W'(a_r);
  assign b_w   = PROD_W'(b_r);

  // operand select for the shared multiplier
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    if (cmd.mul1) begin
      case (op_mode_r)
        MODE_MUL: begin
          mul_x = a_x;
          mul_y = b_r;
        end
        MODE_LOWPASS: begin
          mul_x = b_x;
          mul_y = VAL_W'(LP_TAKE);
        end
        MODE_WEIGHTED: begin
          mul_x = a_x + (b_x <<< 1);
          mul_y = VAL_W'(THIRD_Q16);
        end
        MODE_QUANT: begin
          mul_x = a_abs;
          mul_y = VAL_W'(QUANT_GAIN);
        end
        default: begin
          mul_x = '0;
        end
      endcase
    end else begin
      case (op_mode_r)
        MODE_LOWPASS: begin
          mul_x = MUL_X_W'(z_r);
          mul_y = VAL_W'(LP_KEEP);
        end
        MODE_QUANT: begin
          mul_x = b_x;
          mul_y = {{(VAL_W-SW){1'b0}}, steps_r};
        end
        default: begin
          mul_x = '0;
        end
      endcase
    end
  end

  assign prod_nxt = mul_x * mul_y;

  // step count from floor(|a|*15 / ONE) + 1, saturated
  assign steps_raw = prod_r >>> FRAC_BITS;
  assign steps_nxt = (steps_raw >= PROD_W'(MAX_STEPS)) ? SW'(MAX_STEPS)
                                                      : SW'(steps_raw + PROD_W'(1));

  // truncated q = b*steps / ONE, dividend is |q| * ONE
  assign p_mag = prod_r[PROD_W-1] ? -prod_r : prod_r;
  assign dvd   = (p_mag >>> FRAC_BITS) <<< FRAC_BITS;

  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign rem_ge = (rem_sh >= {1'b0, steps_r});

  assign quo_w   = PROD_W'(quo_r);
  assign quant_v = (PROD_W'(a_abs) == ONE_W) ? clip_one(b_w)
                                             : clip_one(neg_r ? -quo_w : quo_w);

  assign a_gt_half = (a_w > HALF_W);
  assign a_ge_half = (a_w >= HALF_W);
  assign b_gt_half = (b_w > HALF_W);
  assign lp_v      = sat_val(acc_r >>> COEF_SHIFT);

  always_comb begin
    z_nxt    = z_r;
    held_nxt = held_r;
    gate_nxt = gate_r;
    res_w    = '0;
    case (op_mode_r)
      MODE_ADD:      res_w = a_w + b_w;
      MODE_SUB:      res_w = a_w - b_w;
      MODE_MUL:      res_w = acc_r >>> FRAC_BITS;
      MODE_MEAN:     res_w = (a_w + b_w) >>> 1;
      MODE_HALFA_B:  res_w = (a_w >>> 1) + b_w;
      MODE_QUANT:    res_w = quant_v;
      MODE_LOWPASS: begin
        z_nxt = lp_v;
        res_w = PROD_W'(lp_v);
      end
      MODE_SAMPLE: begin
        if (a_gt_half && !gate_r) begin
          held_nxt = b_r;
        end
        gate_nxt = a_ge_half;
        res_w    = PROD_W'(held_nxt);
      end
      MODE_TRACK: begin
        if (a_gt_half) begin
          held_nxt = b_r;
        end
        res_w = PROD_W'(held_nxt);
      end
      MODE_OR:       res_w = (a_gt_half || b_gt_half) ? ONE_W : '0;
      MODE_MAX:      res_w = (a_w > b_w) ? a_w : b_w;
      MODE_MIN:      res_w = (a_w < b_w) ? a_w : b_w;
      MODE_WEIGHTED: res_w = acc_r >>> COEF_SHIFT;
      MODE_ABSDIFF:  res_w = (a_w > b_w) ? (a_w - b_w) : (b_w - a_w);
      default:       res_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r   <= MODE_ZERO;
      z_r         <= '0;
      held_r      <= '0;
      gate_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        op_mode_r <= mode_t'(cfg_data);
      end
      if (cmd.load && in_note) begin
        z_r    <= '0;
        held_r <= '0;
        gate_r <= 1'b0;
      end else if (cmd.fin) begin
        z_r    <= z_nxt;
        held_r <= held_nxt;
        gate_r <= gate_nxt;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= in_a;
      b_r <= in_b;
    end
    if (cmd.mul1 || cmd.mul2) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc1) begin
      steps_r <= steps_nxt;
      if (op_mode_r == MODE_LOWPASS || op_mode_r == MODE_WEIGHTED) begin
        acc_r <= prod_r + PROD_W'(ROUND_Q16);
      end else begin
        acc_r <= prod_r;
      end
    end
    if (cmd.acc2) begin
      acc_r <= acc_r + prod_r;
      quo_r <= dvd[DW-1:0];
      neg_r <= prod_r[PROD_W-1];
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? SW'(rem_sh - {1'b0, steps_r}) : rem_sh[SW-1:0];
      quo_r <= {quo_r[DW-2:0], rem_ge};
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.fin) begin
      res_r <= sat_val(res_w);
    end
  end

  assign status.quant    = (op_mode_r == MODE_QUANT);
  assign status.div_done = (cnt_r == CW'(DW - 1));
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_result = res_r;

endmodule
`default_nettype wire

// ----- rtl/control_signal_combiner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// control_signal_combiner
// Combines two signed fixed-point control values under a configured mode.
// ----------------------------------------------------------------------------
// One word in gives one word out. A word is taken only while the sequencer is
// idle; it then runs through two multiply/accumulate passes on one shared
// multiplier and a finish step before the next word is taken. Quantize mode
// adds a one-bit-per-cycle divider pass over all the quotient bits, which are
// 23 + clog2(MAX_STEPS+1) wide (28 at the default), before the finish step.
// The result sits in an output register, so a new word is accepted while the
// previous result still waits; the sequencer holds in its last step only if
// that register is still full when the next result is ready.
// ----------------------------------------------------------------------------
module control_signal_combiner import ccomb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [MODE_W-1:0] cfg_data,
  ccomb_in_if.sink               in_if,
  ccomb_out_if.source            out_if
);

  ccomb_cmd_t    cmd;
  ccomb_status_t status;
  logic          in_ready;
  logic          out_valid;
  logic signed [VAL_W-1:0] out_result;

  ccomb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ccomb_dp #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_a       (in_if.a_value),
    .in_b       (in_if.b_value),
    .in_note    (in_if.note_start),
    .out_valid  (out_valid),
    .out_ready  (out_if.ready),
    .out_result (out_result)
  );

  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid;
  assign out_if.result_value = out_result;

endmodule
`default_nettype wire

// ----- bench/tb_control_signal_combiner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_control_signal_combiner
// Drives words of two control values and a note start flag through every mode
// and checks each result word against a behavioural model or a table value.
// A table of edge cases comes first, then runs of random words, one mode per
// run, under three idling patterns and one long result stall.
// ----------------------------------------------------------------------------
module tb_control_signal_combiner;
  import ccomb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 4'd15;

  localparam int UNIT      = 1 << FRAC_BITS_DEF;
  localparam int HALF_UNIT = UNIT / 2;

  localparam logic signed [VAL_W-1:0] S_MAX     = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] S_MIN     = 24'sh800000;
  localparam logic signed [VAL_W-1:0] S_ONE     = 24'sh010000;
  localparam logic signed [VAL_W-1:0] S_NEG_ONE = 24'shFF0000;
  localparam logic signed [VAL_W-1:0] S_HALF    = 24'sh008000;
  localparam logic signed [VAL_W-1:0] S_HALF_UP = 24'sh008001;
  localparam logic signed [VAL_W-1:0] S_ZERO    = 24'sd0;

  localparam int NUM_DIR        = 25;
  localparam int NUM_SEGS       = 30;
  localparam int SEGS_PER_PHASE = 10;
  localparam int SEG_WORDS      = 60;
  localparam int PRESSURE_SEG   = 24;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic                    ns;
    logic                    typed;
    logic signed [VAL_W-1:0] want;
  } dir_vec_t;

  // typed = 1: want is checked as given; otherwise the model supplies it
  localparam dir_vec_t DIR_VECS [NUM_DIR] = '{
    '{MODE_ZERO,     S_MAX,      S_MIN,        1'b0, 1'b1, S_ZERO},
    '{MODE_ADD,      S_MAX,      S_MAX,        1'b0, 1'b1, S_MAX},
    '{MODE_ADD,      S_MIN,      S_MIN,        1'b1, 1'b1, S_MIN},
    '{MODE_SUB,      S_MAX,      S_MIN,        1'b0, 1'b1, S_MAX},
    '{MODE_MUL,      S_MIN,      S_MIN,        1'b0, 1'b1, S_MAX},
    '{MODE_MUL,      S_MIN,      S_MAX,        1'b0, 1'b1, S_MIN},
    '{MODE_MEAN,     -24'sd1,    S_ZERO,       1'b0, 1'b0, S_ZERO},
    '{MODE_HALFA_B,  S_MAX,      S_MAX,        1'b0, 1'b1, S_MAX},
    '{MODE_QUANT,    S_ONE,      S_MAX,        1'b0, 1'b1, S_ONE},
    '{MODE_QUANT,    S_NEG_ONE,  S_MIN,        1'b0, 1'b1, S_NEG_ONE},
    '{MODE_QUANT,    S_MIN,      -24'sd30000,  1'b0, 1'b0, S_ZERO},
    '{MODE_LOWPASS,  S_MIN,      S_MAX,        1'b1, 1'b0, S_ZERO},
    '{MODE_LOWPASS,  S_MAX,      S_MAX,        1'b0, 1'b0, S_ZERO},
    '{MODE_SAMPLE,   S_MAX,      24'sd1234,    1'b1, 1'b1, 24'sd1234},
    '{MODE_SAMPLE,   S_MAX,      24'sd5678,    1'b0, 1'b1, 24'sd1234},
    '{MODE_SAMPLE,   S_HALF,     24'sd99,      1'b0, 1'b0, S_ZERO},
    '{MODE_TRACK,    S_HALF_UP,  -24'sd777,    1'b0, 1'b1, -24'sd777},
    '{MODE_TRACK,    S_HALF,     24'sd555,     1'b0, 1'b1, -24'sd777},
    '{MODE_OR,       S_HALF,     S_HALF,       1'b0, 1'b1, S_ZERO},
    '{MODE_OR,       S_HALF_UP,  S_MIN,        1'b0, 1'b1, S_ONE},
    '{MODE_MAX,      S_MIN,      S_MAX,        1'b0, 1'b1, S_MAX},
    '{MODE_MIN,      S_MIN,      S_MAX,        1'b0, 1'b1, S_MIN},
    '{MODE_WEIGHTED, S_MIN,      S_MIN,        1'b0, 1'b0, S_ZERO},
    '{MODE_ABSDIFF,  S_MAX,      S_MIN,        1'b0, 1'b1, S_MAX},
    '{MODE_UNUSED,   S_MAX,      S_MAX,        1'b1, 1'b1, S_ZERO}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_data;

  ccomb_in_if  in_ch ();
  ccomb_out_if out_ch ();

  control_signal_combiner u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  // model state
  logic [MODE_W-1:0] cur_mode      = MODE_ZERO;
  longint            lp_level      = 0;
  longint            hold_level    = 0;
  bit                gate_was_high = 1'b0;

  logic signed [VAL_W-1:0] combined_pending [$];

  int src_idle_pct = 38;
  int snk_idle_pct = 63;
  int stall_asked  = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp_level(input longint v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return v;
  endfunction

  function automatic logic signed [VAL_W-1:0] combine_word(
    input logic signed [VAL_W-1:0] a_in,
    input logic signed [VAL_W-1:0] b_in,
    input logic                    ns
  );
    longint a, b, r, m, steps, q;
    a = a_in;
    b = b_in;
    r = 0;
    if (ns) begin
      lp_level      = 0;
      hold_level    = 0;
      gate_was_high = 1'b0;
    end
    case (cur_mode)
      MODE_ADD:      r = a + b;
      MODE_SUB:      r = a - b;
      MODE_MUL:      r = (a * b) >>> FRAC_BITS_DEF;
      MODE_MEAN:     r = (a + b) >>> 1;
      MODE_HALFA_B:  r = (a >>> 1) + b;
      MODE_QUANT: begin
        m = (a < 0) ? -a : a;
        if (m == UNIT) begin
          r = b;
        end else begin
          steps = ((m * QUANT_GAIN) >>> FRAC_BITS_DEF) + 1;
          if (steps > MAX_STEPS_DEF) steps = MAX_STEPS_DEF;
          q = (b * steps) / UNIT;
          r = (q * UNIT) / steps;
        end
        if (r > UNIT) r = UNIT;
        else if (r < -UNIT) r = -UNIT;
      end
      MODE_LOWPASS: begin
        lp_level = clamp_level((b * LP_TAKE + lp_level * LP_KEEP + ROUND_Q16) >>> COEF_SHIFT);
        r = lp_level;
      end
      MODE_SAMPLE: begin
        if (a > HALF_UNIT && !gate_was_high) hold_level = b;
        gate_was_high = (a >= HALF_UNIT);
        r = hold_level;
      end
      MODE_TRACK: begin
        if (a > HALF_UNIT) hold_level = b;
        r = hold_level;
      end
      MODE_OR:       r = (a > HALF_UNIT || b > HALF_UNIT) ? UNIT : 0;
      MODE_MAX:      r = (a > b) ? a : b;
      MODE_MIN:      r = (a < b) ? a : b;
      MODE_WEIGHTED: r = ((a + 2 * b) * THIRD_Q16 + ROUND_Q16) >>> COEF_SHIFT;
      MODE_ABSDIFF:  r = (a > b) ? a - b : b - a;
      default:       r = 0;
    endcase
    r = clamp_level(r);
    return r[VAL_W-1:0];
  endfunction

  // biased towards the gate threshold, the unit range and the extremes
  function automatic logic signed [VAL_W-1:0] rand_level();
    int v;
    case ($urandom_range(0, 9))
      0:       v = ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
      1, 2, 3: v = $urandom();
      4, 5: begin
        v = HALF_UNIT + int'($urandom_range(0, 8)) - 4;
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      6, 7, 8: v = int'($urandom_range(0, 4 * UNIT)) - 2 * UNIT;
      default: v = ($urandom_range(0, 1) != 0) ? UNIT : -UNIT;
    endcase
    return v[VAL_W-1:0];
  endfunction

  // called just after a rising edge; returns just after the accepting edge
  task automatic push_word(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b,
    input logic                    ns,
    input logic                    typed,
    input logic signed [VAL_W-1:0] want
  );
    logic signed [VAL_W-1:0] due;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.a_value    <= a;
    in_ch.b_value    <= b;
    in_ch.note_start <= ns;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    due = combine_word(a, b, ns);
    combined_pending.push_back(typed ? want : due);
  endtask

  task automatic drain_idle();
    in_ch.valid <= 1'b0;
    while (combined_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] mode);
    drain_idle();
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode = mode;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.a_value    = '0;
    in_ch.b_value    = '0;
    in_ch.note_start = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      if (i == 0 || DIR_VECS[i].mode != cur_mode) set_mode(DIR_VECS[i].mode);
      push_word(DIR_VECS[i].a, DIR_VECS[i].b, DIR_VECS[i].ns,
                DIR_VECS[i].typed, DIR_VECS[i].want);
    end

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg == SEGS_PER_PHASE) begin
        src_idle_pct = 63;
        snk_idle_pct = 38;
      end else if (seg == 2 * SEGS_PER_PHASE) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      set_mode(MODE_W'((seg * 7 + 3) % 16));
      if (seg == PRESSURE_SEG) stall_asked++;
      for (int n = 0; n < SEG_WORDS; n++)
        push_word(rand_level(), rand_level(), ($urandom_range(0, 15) == 0), 1'b0, S_ZERO);
    end

    drain_idle();
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin : sink_side
    int hold_left;
    int stall_taken;
    hold_left    = 0;
    stall_taken  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && stall_taken != stall_asked) begin
        stall_taken = stall_asked;
        hold_left   = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // handshakes are sampled mid-cycle, the word moves at the next rising edge
  always @(negedge clk) begin : result_check
    logic signed [VAL_W-1:0] due_value;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (combined_pending.size() == 0) begin
        $display("%0t: result word %0d arrived with nothing outstanding",
                 $time, out_ch.result_value);
        mismatches++;
      end else begin
        due_value = combined_pending.pop_front();
        if (out_ch.result_value !== due_value) begin
          $display("%0t: result_value mismatch: expected %0d, got %0d",
                   $time, due_value, out_ch.result_value);
          mismatches++;
        end
      end
    end
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

endmodule
